FILE: rtl/ibu_pkg.sv
// Shared types, constants and helper functions for the interleaved bit unpacker.
// No dependencies; every other rtl file refers to it by scoped names.
package ibu_pkg;

  localparam int ElemBits    = 32;
  localparam int BlockValues = 1024;
  localparam int Lanes       = BlockValues / ElemBits;
  localparam int LaneW       = $clog2(Lanes);
  localparam int RowW        = $clog2(ElemBits);
  localparam int WidthW      = 6;
  localparam int IndexW      = 10;
  localparam int BitPosW     = $clog2(ElemBits * ElemBits);

  typedef logic [ElemBits-1:0] word_t;
  typedef logic [WidthW-1:0]   width_t;
  typedef logic [LaneW-1:0]    lane_t;
  typedef logic [RowW-1:0]     row_t;
  typedef logic [ElemBits-1:0] row_mask_t;

  // One accepted word together with what the emitter needs to split it
  typedef struct packed {
    word_t     cur;
    word_t     prev;
    row_t      word_idx;
    lane_t     lane;
    width_t    width;
    row_mask_t mask;
  } item_t;

  // Emitter progress as seen by the ingest side
  typedef struct packed {
    logic adv;
    logic last;
  } emit_ctl_t;

  // Clamp a written width into 1..ElemBits
  function automatic width_t eff_width(input width_t raw);
    width_t w;
    w = raw;
    if (raw == '0) w = width_t'(1);
    else if (raw > width_t'(ElemBits)) w = width_t'(ElemBits);
    return w;
  endfunction

  // Rows whose last bit falls in container word k of the lane stream
  function automatic row_mask_t rows_ending_in(input width_t w, input row_t k);
    row_mask_t            m;
    logic [BitPosW-1:0]   end_bit;
    for (int r = 0; r < ElemBits; r++) begin
      end_bit = BitPosW'((r + 1) * w - 1);
      m[r]    = (end_bit[BitPosW-1:RowW] == k);
    end
    return m;
  endfunction

  function automatic word_t value_mask(input width_t w);
    word_t m;
    for (int b = 0; b < ElemBits; b++) begin
      m[b] = (width_t'(b) < w);
    end
    return m;
  endfunction

endpackage

FILE: rtl/ibu_ingest.sv
// Input side: width register, word and lane counters, previous-word memory
// and the item register feeding the emitter. Depends on ibu_pkg.
module ibu_ingest (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ibu_pkg::word_t      in_word,
  input  logic                cfg_we,
  input  ibu_pkg::width_t     cfg_wdata,
  input  ibu_pkg::emit_ctl_t  ctl,
  output logic                in_stall,
  output logic                item_valid,
  output ibu_pkg::item_t      item
);

  ibu_pkg::width_t width_r;
  ibu_pkg::row_t   word_cnt_r, word_cnt_nxt;
  ibu_pkg::lane_t  lane_cnt_r, lane_cnt_nxt;
  logic            item_valid_r, item_valid_nxt;
  ibu_pkg::item_t  item_r;
  ibu_pkg::word_t  prev_mem [ibu_pkg::Lanes];
  logic            accept;
  logic            lane_wrap;
  logic [ibu_pkg::RowW:0] word_inc;

  // A new word may enter when the item register is empty or drains this cycle
  assign in_stall = item_valid_r && !(ctl.adv && ctl.last);
  assign accept   = in_valid && !in_stall;

  assign lane_wrap = (lane_cnt_r == ibu_pkg::lane_t'(ibu_pkg::Lanes - 1));
  assign word_inc  = {1'b0, word_cnt_r} + 1'b1;

  always_comb begin
    lane_cnt_nxt = lane_cnt_r;
    word_cnt_nxt = word_cnt_r;
    if (accept) begin
      lane_cnt_nxt = lane_wrap ? '0 : lane_cnt_r + 1'b1;
      if (lane_wrap) begin
        word_cnt_nxt = (word_inc >= width_r) ? '0 : word_inc[ibu_pkg::RowW-1:0];
      end
    end
    item_valid_nxt = item_valid_r;
    if (accept) item_valid_nxt = 1'b1;
    else if (ctl.adv && ctl.last) item_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= ibu_pkg::width_t'(ibu_pkg::ElemBits);
      word_cnt_r   <= '0;
      lane_cnt_r   <= '0;
      item_valid_r <= 1'b0;
    end else if (cfg_we) begin
      // restart the block on a width change
      width_r      <= ibu_pkg::eff_width(cfg_wdata);
      word_cnt_r   <= '0;
      lane_cnt_r   <= '0;
      item_valid_r <= item_valid_nxt;
    end else begin
      word_cnt_r   <= word_cnt_nxt;
      lane_cnt_r   <= lane_cnt_nxt;
      item_valid_r <= item_valid_nxt;
    end
  end

  // Read the lane's stored word and overwrite it on the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_mem[lane_cnt_r] <= in_word;
      item_r.prev          <= prev_mem[lane_cnt_r];
      item_r.cur           <= in_word;
      item_r.word_idx      <= word_cnt_r;
      item_r.lane          <= lane_cnt_r;
      item_r.width         <= width_r;
      item_r.mask          <= ibu_pkg::rows_ending_in(width_r, word_cnt_r);
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/ibu_emit.sv
// Emitter: walks the rows of the held word lowest first, extracts each value
// and drives the output register. Depends on ibu_pkg.
module ibu_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  ibu_pkg::item_t             item,
  input  logic                       out_stall,
  output ibu_pkg::emit_ctl_t         ctl,
  output logic                       out_valid,
  output ibu_pkg::word_t             out_value,
  output logic [ibu_pkg::IndexW-1:0] out_index,
  output logic                       out_last,
  output logic                       out_done
);

  ibu_pkg::row_mask_t sent_r, sent_nxt;
  ibu_pkg::row_mask_t pending, low_bit;
  ibu_pkg::row_t      row;
  logic               can_adv, is_last;
  logic [ibu_pkg::BitPosW-1:0] start_bit;
  logic [ibu_pkg::RowW-1:0]    shift_lo;
  logic [ibu_pkg::RowW:0]      shamt;
  logic [2*ibu_pkg::ElemBits-1:0] pair, shifted;
  ibu_pkg::word_t     value;
  logic               out_valid_r, out_valid_nxt;
  ibu_pkg::word_t     out_value_r;
  logic [ibu_pkg::IndexW-1:0] out_index_r;
  logic               out_last_r, out_done_r;

  assign pending = item.mask & ~sent_r;
  assign low_bit = pending & (~pending + 1'b1);
  assign is_last = ((pending & ~low_bit) == '0);

  always_comb begin
    row = '0;
    for (int r = 0; r < ibu_pkg::ElemBits; r++) begin
      if (low_bit[r]) row = ibu_pkg::row_t'(r);
    end
  end

  // Value start within the lane stream; a value that begins in an earlier
  // word takes its low bits from the stored previous word
  assign start_bit = ibu_pkg::BitPosW'(row) * ibu_pkg::BitPosW'(item.width);
  assign shift_lo  = start_bit[ibu_pkg::RowW-1:0];
  assign shamt     = (start_bit[ibu_pkg::BitPosW-1:ibu_pkg::RowW] == item.word_idx) ?
                     {1'b1, shift_lo} : {1'b0, shift_lo};
  assign pair      = {item.cur, item.prev};
  assign shifted   = pair >> shamt;
  assign value     = shifted[ibu_pkg::ElemBits-1:0] & ibu_pkg::value_mask(item.width);

  assign can_adv = item_valid && (!out_valid_r || !out_stall);
  assign ctl     = '{adv: can_adv, last: is_last};

  always_comb begin
    sent_nxt = sent_r;
    if (can_adv) sent_nxt = is_last ? '0 : (sent_r | low_bit);
    out_valid_nxt = out_valid_r && out_stall;
    if (can_adv) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_adv) begin
      out_value_r <= value;
      out_index_r <= ibu_pkg::IndexW'({row, item.lane});
      out_last_r  <= is_last;
      out_done_r  <= (row == ibu_pkg::row_t'(ibu_pkg::ElemBits - 1)) &&
                     (item.lane == ibu_pkg::lane_t'(ibu_pkg::Lanes - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

endmodule

FILE: rtl/interleaved_bit_unpacker_core.sv
// Top level of the interleaved bit unpacker: ingest stage plus emitter.
// Depends on ibu_pkg, ibu_ingest and ibu_emit.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_packed_word
//   out_     output     out_valid / out_stall out_value, out_out_index,
//                                             out_last_of_run, out_block_done
//   cfg_     input      cfg_we                cfg_wdata (packed width)
//
// Each word yields 1 to 32 values (32/w rounded down or up, 32 at width 1),
// one per cycle while out_stall is low. The next word is taken in the cycle
// its predecessor's last value moves into the output register, so there are
// no gaps. Reset is synchronous and clears the counters and valids; the
// previous-word memory is not cleared. out_stall holds the output register and
// the emitter; the input stays stalled until the held word's last value has
// moved to the output.
module interleaved_bit_unpacker_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ibu_pkg::word_t             in_packed_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ibu_pkg::word_t             out_value,
  output logic [ibu_pkg::IndexW-1:0] out_out_index,
  output logic                       out_last_of_run,
  output logic                       out_block_done,
  input  logic                       cfg_we,
  input  ibu_pkg::width_t            cfg_wdata
);

  ibu_pkg::emit_ctl_t ctl;
  ibu_pkg::item_t     item;
  logic               item_valid;

  ibu_ingest u_ingest (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_word    (in_packed_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ctl        (ctl),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  ibu_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_stall  (out_stall),
    .ctl        (ctl),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .out_index  (out_out_index),
    .out_last   (out_last_of_run),
    .out_done   (out_block_done)
  );

  // Last row of the last lane always closes its word
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_done |-> out_last_of_run)
    else $error("block_done without last_of_run");

  // Rows of one word follow without a gap
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("gap inside a run");

  // A run stays in one lane
  a_run_lane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
      out_out_index[ibu_pkg::LaneW-1:0] == $past(out_out_index[ibu_pkg::LaneW-1:0]))
    else $error("lane changed inside a run");

endmodule

FILE: dv/interleaved_bit_unpacker_core_test.sv
`timescale 1ns / 1ps
// Testbench for interleaved_bit_unpacker_core: drives packed words and widths and
// checks every unpacked value against a per-lane prediction. Depends on ibu_pkg.
module interleaved_bit_unpacker_core_test;

  localparam int StallLimit = 2000;

  typedef struct {
    ibu_pkg::word_t             value;
    logic [ibu_pkg::IndexW-1:0] index;
    logic                       last;
    logic                       done;
  } unpacked_t;

  class value_tracker;
    unpacked_t       due_values[$];
    ibu_pkg::word_t  lane_prev[ibu_pkg::Lanes];
    ibu_pkg::width_t width_reg;
    int unsigned     word_idx;
    int unsigned     lane_idx;
    int unsigned     mismatches;

    function new();
      width_reg  = ibu_pkg::width_t'(ibu_pkg::ElemBits);
      word_idx   = 0;
      lane_idx   = 0;
      mismatches = 0;
    endfunction

    // A width write restarts the block
    function void set_width(ibu_pkg::width_t raw);
      width_reg = raw;
      word_idx  = 0;
      lane_idx  = 0;
    endfunction

    // Split one accepted word into the values whose last bit it holds
    function void take_word(ibu_pkg::word_t cur);
      unpacked_t   run[ibu_pkg::ElemBits];
      int unsigned w, k, l, sh, n;
      logic [63:0] v, vmask;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > ibu_pkg::ElemBits) w = ibu_pkg::ElemBits;
      k = (word_idx >= w) ? 0 : word_idx;
      l = lane_idx;
      vmask = (64'd1 << w) - 64'd1;
      n = 0;
      for (int r = 0; r < ibu_pkg::ElemBits; r++) begin
        if ((r * w + w - 1) / ibu_pkg::ElemBits != k) continue;
        sh = (r * w) % ibu_pkg::ElemBits;
        if ((r * w) / ibu_pkg::ElemBits == k) begin
          v = {32'd0, cur} >> sh;
        end else begin
          // straddling value: low part comes from this lane's previous word
          v = ({32'd0, lane_prev[l]} >> sh) |
              (({32'd0, cur} << (ibu_pkg::ElemBits - sh)) & 64'hFFFF_FFFF);
        end
        run[n].value = ibu_pkg::word_t'(v & vmask);
        run[n].index = ibu_pkg::IndexW'(r * ibu_pkg::Lanes + l);
        run[n].last  = 1'b0;
        run[n].done  = (r == ibu_pkg::ElemBits - 1) && (l == ibu_pkg::Lanes - 1);
        n++;
      end
      if (n > 0) run[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) due_values.insert(due_values.size(), run[i]);
      lane_prev[l] = cur;
      l++;
      if (l >= ibu_pkg::Lanes) begin
        l = 0;
        k++;
        if (k >= w) k = 0;
      end
      word_idx = k;
      lane_idx = l;
    endfunction

    task report_miss(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task match_value(ibu_pkg::word_t value, logic [ibu_pkg::IndexW-1:0] index,
                     logic last, logic done);
      unpacked_t e;
      if (due_values.size() == 0) begin
        report_miss($sformatf("unexpected value %h at index %0d", value, index));
        return;
      end
      e = due_values.pop_front();
      if (value !== e.value || index !== e.index || last !== e.last || done !== e.done)
        report_miss($sformatf(
          "got value %h idx %0d last %b done %b, want value %h idx %0d last %b done %b",
          value, index, last, done, e.value, e.index, e.last, e.done));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  ibu_pkg::word_t             in_packed_word = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  ibu_pkg::word_t             out_value;
  logic [ibu_pkg::IndexW-1:0] out_out_index;
  logic                       out_last_of_run;
  logic                       out_block_done;
  logic                       cfg_we = 1'b0;
  ibu_pkg::width_t            cfg_wdata = '0;
  bit                         no_idle = 1'b0;
  int unsigned                quiet_cycles = 0;
  value_tracker               tracker = new();

  interleaved_bit_unpacker_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_packed_word  (in_packed_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_out_index   (out_out_index),
    .out_last_of_run (out_last_of_run),
    .out_block_done  (out_block_done),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.match_value(out_value, out_out_index, out_last_of_run, out_block_done);
    out_stall <= rst_n && !no_idle && ($urandom_range(99, 0) < 15);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input ibu_pkg::word_t data);
    if (!no_idle)
      while ($urandom_range(99, 0) < 15) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid       <= 1'b1;
    in_packed_word <= data;
    do @(posedge clk); while (in_stall);
    tracker.take_word(data);
  endtask

  // Drop valid and hold until every predicted value has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input ibu_pkg::width_t raw);
    cfg_we    <= 1'b1;
    cfg_wdata <= raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_width(raw);
  endtask

  initial begin
    ibu_pkg::word_t  patterns[4];
    ibu_pkg::word_t  data;
    ibu_pkg::width_t raw;
    int unsigned     sent, count, eff, phase;
    bit              paused;
    patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width: one value per word
    foreach (patterns[i]) send_word(patterns[i]);
    drain();
    write_width(ibu_pkg::width_t'(1));
    foreach (patterns[i]) send_word(patterns[i]);
    drain();
    // zero acts as width one
    write_width(ibu_pkg::width_t'(0));
    send_word(32'h8000_0001);
    send_word($urandom());
    drain();
    // widths above the element width clamp to it
    write_width(ibu_pkg::width_t'(63));
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    drain();
    write_width(ibu_pkg::width_t'(33));
    send_word($urandom());
    drain();
    write_width(ibu_pkg::width_t'(5));
    repeat (3) send_word($urandom());
    drain();
    // rewrite mid-block: counters restart
    write_width(ibu_pkg::width_t'(5));
    repeat (2) send_word($urandom());
    drain();

    sent   = 0;
    phase  = 0;
    paused = 1'b0;
    while (sent < 460) begin
      case ($urandom_range(3, 0))
        0:       raw = ibu_pkg::width_t'($urandom_range(63, 0));
        1:       raw = ibu_pkg::width_t'($urandom_range(4, 0));
        default: raw = ibu_pkg::width_t'($urandom_range(12, 1));
      endcase
      eff = (raw == 0) ? 1 : (raw > ibu_pkg::ElemBits) ? ibu_pkg::ElemBits : raw;
      // short blocks run to completion and wrap into the next one
      if (eff * ibu_pkg::Lanes <= 160 && $urandom_range(1, 0) == 1)
        count = eff * ibu_pkg::Lanes + $urandom_range(40, 1);
      else
        count = $urandom_range(90, 20);
      if (phase == 2) count = 120;
      if (count > 460 - sent) count = 460 - sent;
      no_idle = (phase == 2);
      write_width(raw);
      for (int i = 0; i < count; i++) begin
        if (!paused && phase == 1 && i == count / 2) begin
          drain();
          paused = 1'b1;
        end
        case ($urandom_range(9, 0))
          0:       data = '0;
          1:       data = '1;
          default: data = $urandom();
        endcase
        send_word(data);
      end
      sent += count;
      drain();
      phase++;
    end
    no_idle = 1'b0;

    repeat (64) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
